// File: rtl/length_prefixed_nal_keyframe_detector_top_macros.svh
// Assertion helpers used by the RTL module lpnk_scan.
`ifndef LENGTH_PREFIXED_NAL_KEYFRAME_DETECTOR_TOP_MACROS_SVH
`define LENGTH_PREFIXED_NAL_KEYFRAME_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LPNK_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lpnk assertion failed");

// Next-cycle implication, disabled while reset is low.
`define LPNK_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lpnk assertion failed");

`endif

// File: rtl/lpnk_pkg.sv
`timescale 1ns / 1ps

package lpnk_pkg;

    localparam logic [7:0] H264_TYPE_MASK  = 8'h1F;
    localparam logic [7:0] HEVC_TYPE_MASK  = 8'h7E;
    localparam logic [7:0] BYTE_MASK       = 8'hFF;
    localparam logic [4:0] H264_IDR        = 5'd5;
    localparam logic [5:0] HEVC_IRAP_FIRST = 6'd16;
    localparam logic [5:0] HEVC_IRAP_LAST  = 6'd21;

    // Configuration register indexes.
    localparam logic CFG_SCAN_NAL_UNITS = 1'b0;
    localparam logic CFG_CODEC_IS_HEVC  = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       key;
    } byte_item_t;

    // True when a NAL header byte marks an IDR (H.264) or IRAP (HEVC) unit.
    function automatic logic nal_is_irap(input logic [7:0] hdr, input logic hevc);
        logic [7:0] masked;
        logic [5:0] nal_type;
        begin
            if (hevc) begin
                masked   = (hdr & BYTE_MASK) & HEVC_TYPE_MASK;
                nal_type = masked[6:1];
                nal_is_irap = nal_type inside {[HEVC_IRAP_FIRST:HEVC_IRAP_LAST]};
            end else begin
                masked = hdr & H264_TYPE_MASK;
                nal_is_irap = (masked[4:0] == H264_IDR);
            end
        end
    endfunction

endpackage

// File: rtl/lpnk_scan.sv
`timescale 1ns / 1ps

`include "length_prefixed_nal_keyframe_detector_top_macros.svh"

module lpnk_scan #(
    parameter int OFFSET_BITS = 31
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_acc,
    input  lpnk_pkg::byte_item_t item,
    input  logic                 codec_is_hevc,
    output logic                 hit_now
);
    import lpnk_pkg::*;

    localparam int PW = OFFSET_BITS + 1;
    localparam int RW = OFFSET_BITS + 2;

    logic [PW-1:0]          pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [31:0]            len_reg, len_next;
    logic                   match_reg, match_next;
    logic                   halt_reg, halt_next;

    logic [RW-1:0] rel;
    logic [RW-1:0] sum;
    logic          behind, active, rel_lt4, rel_eq4, ovf, hdr_hit;

    // The counter saturates well past any reachable unit start plus four,
    // so a saturated offset never meets a unit again.
    always_comb begin
        behind  = pos_reg < {1'b0, start_reg};
        rel     = {1'b0, pos_reg} - {2'b00, start_reg};
        rel_lt4 = !behind && (rel[RW-1:2] == '0);
        rel_eq4 = !behind && (rel == RW'(4));
        active  = !halt_reg && !match_reg;
        sum     = {2'b00, start_reg} + {2'b00, len_reg[OFFSET_BITS-1:0]} + RW'(4);
        ovf     = (len_reg[31:OFFSET_BITS] != '0) || (sum[RW-1:OFFSET_BITS] != '0);
        hdr_hit = nal_is_irap(item.data, codec_is_hevc);
        hit_now = match_reg || (active && rel_eq4 && hdr_hit);
    end

    always_comb begin
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        match_next = match_reg;
        halt_next  = halt_reg;
        if (item_acc) begin
            if (item.last) begin
                pos_next   = '0;
                start_next = '0;
                len_next   = '0;
                match_next = 1'b0;
                halt_next  = 1'b0;
            end else begin
                if (active && rel_lt4) begin
                    len_next = {len_reg[23:0], item.data};
                end else if (active && rel_eq4) begin
                    if (hdr_hit) begin
                        match_next = 1'b1;
                    end else if (ovf) begin
                        halt_next = 1'b1;
                    end else begin
                        start_next = sum[OFFSET_BITS-1:0];
                        len_next   = '0;
                    end
                end
                if (pos_reg != '1) begin
                    pos_next = pos_reg + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            match_reg <= 1'b0;
            halt_reg  <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            match_reg <= match_next;
            halt_reg  <= halt_next;
        end
    end

    `LPNK_ASSERT_NXT(a_clear_after_last, aclk, aresetn, item_acc && item.last, (pos_reg == '0) && !match_reg && !halt_reg && (len_reg == '0))
    `LPNK_ASSERT_IMP(a_match_halt_excl, aclk, aresetn, 1'b1, !(match_reg && halt_reg))
    `LPNK_ASSERT_NXT(a_len_idle_stable, aclk, aresetn, !item_acc, $stable(len_reg) && $stable(start_reg))

endmodule

// File: rtl/length_prefixed_nal_keyframe_detector_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields (tdata/tuser/tlast)              Transfer
// s_        in   tdata: data_byte; tlast: last_byte;      s_tvalid & s_tready
//                tuser: key_flag
// m_        out  tdata: is_key (bit 0)                    m_tvalid & m_tready
// cfg_      in   cfg_index selects register, cfg_wdata    cfg_wr_en
//
// One byte is taken every cycle unless a last byte stalls; the per-byte scan is one
// compare and add stage. A result is registered the cycle after the last byte is taken.
// While a result waits, bytes keep flowing; only a new last byte stalls until it drains.
// Reset (aresetn low, synchronous) clears the scan state and sets scan mode on, H.264.

module length_prefixed_nal_keyframe_detector_top #(
    parameter int OFFSET_BITS = 31
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    input  logic       s_tuser,   // key_flag
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] is_key, [7:1] zero
);
    import lpnk_pkg::*;

    logic       scan_reg, hevc_reg;
    logic       m_valid_reg, m_valid_next;
    logic       is_key_reg, is_key_next;
    logic       s_acc, hit_now;
    byte_item_t item;

    always_comb begin
        item.data = s_tdata;
        item.last = s_tlast;
        item.key  = s_tuser;
    end

    // A byte without the last mark never needs the output slot.
    assign s_tready = !m_valid_reg || m_tready || !s_tlast;
    assign s_acc    = s_tvalid && s_tready;

    lpnk_scan #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_acc      (s_acc),
        .item          (item),
        .codec_is_hevc (hevc_reg),
        .hit_now       (hit_now)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        is_key_next  = is_key_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_acc && s_tlast) begin
            m_valid_next = 1'b1;
            is_key_next  = scan_reg ? hit_now : s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg    <= 1'b1;
            hevc_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SCAN_NAL_UNITS: scan_reg <= cfg_wdata;
                    CFG_CODEC_IS_HEVC:  hevc_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        is_key_reg <= is_key_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, is_key_reg};

endmodule
